// ===== hw/rtl/tmbc_pkg.sv =====
`timescale 1ns / 1ps

package tmbc_pkg;

    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_TILE_PIXELS = 16;

    // reciprocal scaling for the pixel-to-tile divide
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_BOX   = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_GRID_COLS  = 2'd0,
        CFG_GRID_ROWS  = 2'd1,
        CFG_EMPTY_CODE = 2'd2,
        CFG_WALL_CODE  = 2'd3
    } cfg_reg_t;

endpackage

// ===== hw/rtl/tmbc_ram.sv =====
`timescale 1ns / 1ps

module tmbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tile_map_box_collision.sv =====
`timescale 1ns / 1ps
// A new request is taken only in IDLE, after the previous result is passed to the output.
// Write and unused request type pass EXEC and RESP; read adds RDWAIT for the registered RAM.
// Box query: EXEC, DIV and SETUP, then SCAN unless the clipped box is empty; the scan
// issues one tile read per cycle on the single memory read port and stops early on a hit.
// Reset: config registers return to 64/64/0/1, then a clearing pass zeroes the tile memory,
// all MAX_COLS*MAX_ROWS entries (4096 by default), during which no request is taken.

module tile_map_box_collision #(
    parameter int MAX_COLS    = tmbc_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = tmbc_pkg::DEF_MAX_ROWS,
    parameter int TILE_PIXELS = tmbc_pkg::DEF_TILE_PIXELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tile_x[10:0], tile_y[21:11], tile_value[29:22], box_left[42:30], box_top[55:43],
    // box_width[67:56], box_height[79:68]
    input  logic [tmbc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  logic [tmbc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_code[7:0], hit[8], zero[15:9]
    output logic [tmbc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [tmbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RS    = tmbc_pkg::RECIP_SHIFT;
    localparam int RECIP = (1 << tmbc_pkg::RECIP_SHIFT) / TILE_PIXELS + 1;

    localparam logic [tmbc_pkg::RECIP_W-1:0] RECIP_C    = tmbc_pkg::RECIP_W'(RECIP);
    localparam logic [10:0]                  MAX_COLS_C = 11'(MAX_COLS);
    localparam logic [10:0]                  MAX_ROWS_C = 11'(MAX_ROWS);
    localparam logic signed [13:0]           NEG_T      = 14'sd0 - 14'(TILE_PIXELS);
    localparam logic [AW-1:0]                LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [AW-1:0]                ROW_STRIDE = AW'(MAX_COLS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_SETUP,
        ST_SCAN,
        ST_RDWAIT,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  grid_cols_reg, grid_cols_next;
    logic [6:0]  grid_rows_reg, grid_rows_next;
    logic [7:0]  empty_code_reg, empty_code_next;
    logic [7:0]  wall_code_reg, wall_code_next;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic [1:0]  req_reg, req_next;
    logic [10:0] tx_reg, tx_next;
    logic [10:0] ty_reg, ty_next;
    logic [7:0]  val_reg, val_next;
    logic [12:0] left_reg, left_next;
    logic [12:0] top_reg, top_next;
    logic [11:0] w_reg, w_next;
    logic [11:0] h_reg, h_next;

    logic [12:0] dx0_reg, dx0_next, dx1_reg, dx1_next;
    logic [12:0] dy0_reg, dy0_next, dy1_reg, dy1_next;
    logic        x1_neg_reg, x1_neg_next, y1_neg_reg, y1_neg_next;
    logic [12:0] qx0_reg, qx0_next, qx1_reg, qx1_next;
    logic [12:0] qy0_reg, qy0_next, qy1_reg, qy1_next;

    logic [XW-1:0] x_reg, x_next, x0_reg, x0_next, x1_reg, x1_next;
    logic [YW-1:0] y_reg, y_next, y1_reg, y1_next;
    logic          issue_done_reg, issue_done_next;
    logic          rd_pend_reg, rd_pend_next;

    logic [7:0]  res_code_reg, res_code_next;
    logic        res_hit_reg, res_hit_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_code_reg, out_code_next;
    logic        out_hit_reg, out_hit_next;

    logic [10:0] used_cols, used_rows;
    logic        on_grid;
    logic [AW-1:0] rw_addr, scan_addr;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;

    logic signed [13:0] n1x, n1y;
    logic [35:0] px0, px1, py0, py1;
    logic [12:0] x1c, y1c;
    logic        box_empty;
    logic        in_fire;

    assign used_cols = ({4'b0, grid_cols_reg} < MAX_COLS_C) ? {4'b0, grid_cols_reg} : MAX_COLS_C;
    assign used_rows = ({4'b0, grid_rows_reg} < MAX_ROWS_C) ? {4'b0, grid_rows_reg} : MAX_ROWS_C;

    assign on_grid = !tx_reg[10] && !ty_reg[10]
                  && ({1'b0, tx_reg[9:0]} < used_cols)
                  && ({1'b0, ty_reg[9:0]} < used_rows);

    assign rw_addr   = AW'(ty_reg[YW-1:0]) * ROW_STRIDE + AW'(tx_reg[XW-1:0]);
    assign scan_addr = AW'(y_reg) * ROW_STRIDE + AW'(x_reg);

    assign n1x = $signed({left_reg[12], left_reg}) + $signed({2'b00, w_reg}) - 14'sd1;
    assign n1y = $signed({top_reg[12], top_reg}) + $signed({2'b00, h_reg}) - 14'sd1;

    assign px0 = 36'(dx0_reg) * 36'(RECIP_C);
    assign px1 = 36'(dx1_reg) * 36'(RECIP_C);
    assign py0 = 36'(dy0_reg) * 36'(RECIP_C);
    assign py1 = 36'(dy1_reg) * 36'(RECIP_C);

    assign x1c = (qx1_reg >= 13'(used_cols)) ? 13'(used_cols) - 13'd1 : qx1_reg;
    assign y1c = (qy1_reg >= 13'(used_rows)) ? 13'(used_rows) - 13'd1 : qy1_reg;

    assign box_empty = x1_neg_reg || y1_neg_reg
                    || (used_cols == 11'd0) || (used_rows == 11'd0)
                    || (qx0_reg > x1c) || (qy0_reg > y1c)
                    || (wall_code_reg == empty_code_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign mem_we    = (state_reg == ST_CLEAR)
                    || ((state_reg == ST_EXEC) && (req_reg == tmbc_pkg::REQ_WRITE) && on_grid);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : rw_addr;
    assign mem_wdata = (state_reg == ST_CLEAR) ? 8'd0 : val_reg;
    assign mem_raddr = (state_reg == ST_SCAN) ? scan_addr : rw_addr;

    tmbc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        grid_cols_next  = grid_cols_reg;
        grid_rows_next  = grid_rows_reg;
        empty_code_next = empty_code_reg;
        wall_code_next  = wall_code_reg;
        clr_addr_next   = clr_addr_reg;
        req_next        = req_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        val_next        = val_reg;
        left_next       = left_reg;
        top_next        = top_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        dx0_next        = dx0_reg;
        dx1_next        = dx1_reg;
        dy0_next        = dy0_reg;
        dy1_next        = dy1_reg;
        x1_neg_next     = x1_neg_reg;
        y1_neg_next     = y1_neg_reg;
        qx0_next        = qx0_reg;
        qx1_next        = qx1_reg;
        qy0_next        = qy0_reg;
        qy1_next        = qy1_reg;
        x_next          = x_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        y_next          = y_reg;
        y1_next         = y1_reg;
        issue_done_next = issue_done_reg;
        rd_pend_next    = 1'b0;
        res_code_next   = res_code_reg;
        res_hit_next    = res_hit_reg;
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_hit_next    = out_hit_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                tmbc_pkg::CFG_GRID_COLS:  grid_cols_next  = cfg_data[6:0];
                tmbc_pkg::CFG_GRID_ROWS:  grid_rows_next  = cfg_data[6:0];
                tmbc_pkg::CFG_EMPTY_CODE: empty_code_next = cfg_data;
                tmbc_pkg::CFG_WALL_CODE:  wall_code_next  = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next   = s_axis_tuser;
                    tx_next    = s_axis_tdata[10:0];
                    ty_next    = s_axis_tdata[21:11];
                    val_next   = s_axis_tdata[29:22];
                    left_next  = s_axis_tdata[42:30];
                    top_next   = s_axis_tdata[55:43];
                    w_next     = s_axis_tdata[67:56];
                    h_next     = s_axis_tdata[79:68];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_code_next = 8'd0;
                res_hit_next  = 1'b0;
                state_next    = ST_RESP;
                case (req_reg)
                    tmbc_pkg::REQ_READ:
                    begin
                        if (on_grid)
                        begin
                            state_next = ST_RDWAIT;
                        end
                        else
                        begin
                            res_code_next = empty_code_reg;
                        end
                    end
                    tmbc_pkg::REQ_BOX:
                    begin
                        // negative left/top edge truncates to tile 0
                        dx0_next    = left_reg[12] ? 13'd0 : {1'b0, left_reg[11:0]};
                        dy0_next    = top_reg[12] ? 13'd0 : {1'b0, top_reg[11:0]};
                        dx1_next    = n1x[13] ? 13'd0 : n1x[12:0];
                        dy1_next    = n1y[13] ? 13'd0 : n1y[12:0];
                        x1_neg_next = (n1x <= NEG_T);
                        y1_neg_next = (n1y <= NEG_T);
                        state_next  = ST_DIV;
                    end
                    default: ;
                endcase
            end

            ST_DIV:
            begin
                qx0_next   = px0[RS+12:RS];
                qx1_next   = px1[RS+12:RS];
                qy0_next   = py0[RS+12:RS];
                qy1_next   = py1[RS+12:RS];
                state_next = ST_SETUP;
            end

            ST_SETUP:
            begin
                if (box_empty)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    x_next          = qx0_reg[XW-1:0];
                    x0_next         = qx0_reg[XW-1:0];
                    x1_next         = x1c[XW-1:0];
                    y_next          = qy0_reg[YW-1:0];
                    y1_next         = y1c[YW-1:0];
                    issue_done_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (rd_pend_reg && (mem_rdata == wall_code_reg))
                begin
                    res_hit_next = 1'b1;
                    state_next   = ST_RESP;
                end
                else if (issue_done_reg)
                begin
                    if (!rd_pend_reg)
                    begin
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    if (x_reg == x1_reg)
                    begin
                        x_next = x0_reg;
                        y_next = y_reg + YW'(1);
                        if (y_reg == y1_reg)
                        begin
                            issue_done_next = 1'b1;
                        end
                    end
                    else
                    begin
                        x_next = x_reg + XW'(1);
                    end
                end
            end

            ST_RDWAIT:
            begin
                res_code_next = mem_rdata;
                state_next    = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = res_code_reg;
                    out_hit_next   = res_hit_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            grid_cols_reg  <= 7'd64;
            grid_rows_reg  <= 7'd64;
            empty_code_reg <= 8'd0;
            wall_code_reg  <= 8'd1;
            clr_addr_reg   <= '0;
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            grid_cols_reg  <= grid_cols_next;
            grid_rows_reg  <= grid_rows_next;
            empty_code_reg <= empty_code_next;
            wall_code_reg  <= wall_code_next;
            clr_addr_reg   <= clr_addr_next;
            issue_done_reg <= issue_done_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        val_reg      <= val_next;
        left_reg     <= left_next;
        top_reg      <= top_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        dx0_reg      <= dx0_next;
        dx1_reg      <= dx1_next;
        dy0_reg      <= dy0_next;
        dy1_reg      <= dy1_next;
        x1_neg_reg   <= x1_neg_next;
        y1_neg_reg   <= y1_neg_next;
        qx0_reg      <= qx0_next;
        qx1_reg      <= qx1_next;
        qy0_reg      <= qy0_next;
        qy1_reg      <= qy1_next;
        x_reg        <= x_next;
        x0_reg       <= x0_next;
        x1_reg       <= x1_next;
        y_reg        <= y_next;
        y1_reg       <= y1_next;
        res_code_reg <= res_code_next;
        res_hit_reg  <= res_hit_next;
        out_code_reg <= out_code_next;
        out_hit_reg  <= out_hit_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_hit_reg, out_code_reg};

    a_scan_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !issue_done_reg) |-> (x_reg <= x1_reg && y_reg <= y1_reg))
        else $error("scan position left the clipped box");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_RDWAIT) |-> !mem_we)
        else $error("tile store written during a read or scan");

    a_hit_only_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && res_hit_reg) |-> (req_reg == tmbc_pkg::REQ_BOX))
        else $error("hit set for a non-box request");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed next cycle");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_COLS     = tmbc_pkg::DEF_MAX_COLS;
    localparam int MAX_ROWS     = tmbc_pkg::DEF_MAX_ROWS;
    localparam int TILE_PIX     = tmbc_pkg::DEF_TILE_PIXELS;
    localparam int QUIET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 20000000;

    // request kind that the block must answer with zeros
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic signed [10:0] tx;
        logic signed [10:0] ty;
        logic [7:0]         val;
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic [11:0]        w;
        logic [11:0]        h;
    } map_req_t;

    typedef struct {
        logic [7:0] code;
        logic       hit;
    } map_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [tmbc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [tmbc_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [tmbc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            cfg_we;
    logic [tmbc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tmbc_pkg::CFG_DATA_W-1:0] cfg_data;

    // shadow of the tile map and its registers
    logic [7:0]  tile_shadow [MAX_COLS*MAX_ROWS];
    logic [6:0]  grid_cols;
    logic [6:0]  grid_rows;
    logic [7:0]  empty_code;
    logic [7:0]  wall_code;

    map_result_t pending_results [$];
    map_result_t want;
    int          errors;
    int          cycle_count;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          hold_left;

    tile_map_box_collision dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int cols_in_use();
        return (grid_cols < MAX_COLS) ? int'(grid_cols) : MAX_COLS;
    endfunction

    function automatic int rows_in_use();
        return (grid_rows < MAX_ROWS) ? int'(grid_rows) : MAX_ROWS;
    endfunction

    function automatic map_result_t predict_map_result(input map_req_t r);
        map_result_t res;
        int          tx;
        int          ty;
        int          ncols;
        int          nrows;
        int          left;
        int          top;
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        bit          on_grid;
        res.code = '0;
        res.hit  = 1'b0;
        ncols = cols_in_use();
        nrows = rows_in_use();
        tx = r.tx;
        ty = r.ty;
        on_grid = tx >= 0 && ty >= 0 && tx < ncols && ty < nrows;
        case (r.kind)
            tmbc_pkg::REQ_WRITE:
                if (on_grid)
                    tile_shadow[ty*MAX_COLS + tx] = r.val;
            tmbc_pkg::REQ_READ:
                res.code = on_grid ? tile_shadow[ty*MAX_COLS + tx] : empty_code;
            tmbc_pkg::REQ_BOX:
            begin
                left = r.left;
                top  = r.top;
                // int division truncates toward zero
                x0 = left / TILE_PIX;
                y0 = top / TILE_PIX;
                x1 = (left + int'(r.w) - 1) / TILE_PIX;
                y1 = (top + int'(r.h) - 1) / TILE_PIX;
                if (x0 < 0)
                    x0 = 0;
                if (y0 < 0)
                    y0 = 0;
                if (x1 > ncols - 1)
                    x1 = ncols - 1;
                if (y1 > nrows - 1)
                    y1 = nrows - 1;
                if (wall_code != empty_code)
                    for (int y = y0; y <= y1; y++)
                        for (int x = x0; x <= x1; x++)
                            if (tile_shadow[y*MAX_COLS + x] == wall_code)
                                res.hit = 1'b1;
            end
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic map_req_t build_req(input logic [1:0] kind, input int tx, input int ty,
                                           input int val, input int left, input int top,
                                           input int w, input int h);
        map_req_t r;
        r.kind = kind;
        r.tx   = tx[10:0];
        r.ty   = ty[10:0];
        r.val  = val[7:0];
        r.left = left[12:0];
        r.top  = top[12:0];
        r.w    = w[11:0];
        r.h    = h[11:0];
        return r;
    endfunction

    function automatic logic [10:0] pick_tile(input int span);
        int v;
        case ($urandom_range(9))
            0: v = $urandom_range(2047);
            1: v = $urandom_range(1) ? -int'($urandom_range(1, 3))
                                     : span + int'($urandom_range(3));
            default: v = (span > 0) ? int'($urandom_range(span - 1)) : int'($urandom_range(3));
        endcase
        return v[10:0];
    endfunction

    function automatic logic [12:0] pick_pixel(input int span);
        int v;
        if ($urandom_range(19) < 3)
            v = $urandom_range(8191);
        else
            v = int'($urandom_range(span*TILE_PIX + 80)) - 40;
        return v[12:0];
    endfunction

    function automatic logic [11:0] pick_size(input int span);
        int v;
        case ($urandom_range(19))
            0:       v = $urandom_range(4095);
            1, 2:    v = $urandom_range(span*TILE_PIX + 32);
            default: v = $urandom_range(48);
        endcase
        return v[11:0];
    endfunction

    function automatic map_req_t make_random_req();
        map_req_t r;
        int       sel;
        sel = $urandom_range(99);
        r.kind = (sel < 35) ? tmbc_pkg::REQ_WRITE : (sel < 65) ? tmbc_pkg::REQ_READ :
                 (sel < 95) ? tmbc_pkg::REQ_BOX : REQ_UNUSED;
        r.tx = pick_tile(cols_in_use());
        r.ty = pick_tile(rows_in_use());
        sel = $urandom_range(9);
        r.val = (sel < 4) ? wall_code : (sel == 4) ? empty_code : 8'($urandom);
        r.left = pick_pixel(cols_in_use());
        r.top  = pick_pixel(rows_in_use());
        r.w    = pick_size(cols_in_use());
        r.h    = pick_size(rows_in_use());
        return r;
    endfunction

    task automatic send_req(input map_req_t r);
        @(negedge clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = r.kind;
        s_axis_tdata  = {r.h, r.w, r.top, r.left, r.val, r.ty, r.tx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(predict_map_result(r));
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input tmbc_pkg::cfg_reg_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            tmbc_pkg::CFG_GRID_COLS:  grid_cols  = value[6:0];
            tmbc_pkg::CFG_GRID_ROWS:  grid_rows  = value[6:0];
            tmbc_pkg::CFG_EMPTY_CODE: empty_code = value;
            tmbc_pkg::CFG_WALL_CODE:  wall_code  = value;
        endcase
    endtask

    task automatic set_config(input int cols, input int rows, input logic [7:0] empty,
                              input logic [7:0] wall);
        wait_quiet();
        write_reg(tmbc_pkg::CFG_GRID_COLS, cols[7:0]);
        write_reg(tmbc_pkg::CFG_GRID_ROWS, rows[7:0]);
        write_reg(tmbc_pkg::CFG_EMPTY_CODE, empty);
        write_reg(tmbc_pkg::CFG_WALL_CODE, wall);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_idle(input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // default grid 64x64, empty 0, wall 1
    task automatic test_directed_cases();
        send_req(build_req(tmbc_pkg::REQ_WRITE, 0, 0, 1, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_WRITE, 63, 63, 1, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_WRITE, 63, 0, 255, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_WRITE, -1, 0, 1, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_WRITE, 64, 5, 1, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_WRITE, -1024, 1023, 128, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_READ, 63, 0, 0, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_READ, -1, 0, 0, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_READ, 0, 64, 0, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_READ, 1023, -1024, 0, 0, 0, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_READ, 5, 5, 0, 0, 0, 0, 0));
        // negative corners truncate to tile 0
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, -15, -15, 16, 16));
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, -16, -16, 16, 16));
        // zero size: end tile below start tile
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, 16, 16, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, -4096, -4096, 0, 0));
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, 0, 0, 4095, 4095));
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, 4095, 4095, 4095, 4095));
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, 1008, 1008, 16, 16));
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, 32, 32, 40, 40));
        send_req(build_req(tmbc_pkg::REQ_BOX, 0, 0, 0, -4096, -4096, 4095, 4095));
        send_req(build_req(REQ_UNUSED, -1, -1, 255, -1, -1, 4095, 4095));
        send_req(build_req(tmbc_pkg::REQ_READ, 63, 63, 0, 0, 0, 0, 0));
    endtask

    task automatic test_traffic(input int count, input int cols, input int rows,
                                input logic [7:0] empty, input logic [7:0] wall);
        set_config(cols, rows, empty, wall);
        repeat (count)
            send_req(make_random_req());
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure(input int count);
        wait_quiet();
        set_idle(0, 0);
        hold_left = 300;
        repeat (count)
            send_req(make_random_req());
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
            m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, got %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.code)
                begin
                    $display("%0t: read_code expected %h actual %h",
                             $time, want.code, m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[8] !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, m_axis_tdata[8]);
                    errors++;
                end
                if (m_axis_tdata[15:9] !== '0)
                begin
                    $display("%0t: pad bits expected 0 actual %h", $time, m_axis_tdata[15:9]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        errors        = 0;
        cycle_count   = 0;
        hold_left     = 0;
        set_idle(0, 0);
        foreach (tile_shadow[i])
            tile_shadow[i] = '0;
        grid_cols  = 7'd64;
        grid_rows  = 7'd64;
        empty_code = 8'd0;
        wall_code  = 8'd1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();

        set_idle(13, 69);
        test_traffic(150, 64, 64, 8'h00, 8'h01);
        test_traffic(150, 1, 1, 8'hFF, 8'h00);
        test_traffic(150, 127, 127, 8'hA5, 8'h5A);

        set_idle(69, 13);
        test_traffic(150, 0, 0, 8'h03, 8'h07);
        test_traffic(150, 64, 1, 8'($urandom), 8'($urandom));
        test_traffic(150, 1, 64, 8'($urandom), 8'($urandom));

        set_idle(0, 0);
        test_traffic(130, $urandom_range(1, 64), $urandom_range(1, 64),
                     8'($urandom), 8'($urandom));
        // wall equal to empty never hits
        test_traffic(130, 17, 9, 8'h42, 8'h42);
        test_traffic(130, 64, 64, 8'h00, 8'h01);

        test_backpressure(60);

        wait_quiet();
        if (errors == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tmbc_pkg.sv
hw/rtl/tmbc_ram.sv
hw/rtl/tile_map_box_collision.sv
bench/tb_top.sv
